// ----- design/ptb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the periodic timer bank: sizes, field codes and shared types.
// No dependencies; the other design files but ptb_if refer to it by scoped names.
package ptb_pkg;

  // Number of timer slots and the width of a slot number.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [SLOT_W-1:0] slot_t;

  // Input modes.
  localparam logic [1:0] MODE_REG   = 2'd0;
  localparam logic [1:0] MODE_UNREG = 2'd1;
  localparam logic [1:0] MODE_ADV   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_UNREG  = 2'd2;
  localparam logic [1:0] KIND_EXPIRY = 2'd3;

  // One slot entry as held in the state memory.
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] countdown;
  } slot_ent_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;

endpackage

// ----- design/ptb_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but the field widths of the block.
interface ptb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  slot;
  logic [15:0] period;
  logic [15:0] elapsed_ticks;

  modport source (output valid, mode, slot, period, elapsed_ticks, input ready);
  modport sink   (input valid, mode, slot, period, elapsed_ticks, output ready);
endinterface

interface ptb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  slot_index;
  logic [15:0] expirations;
  logic        last;

  modport source (output valid, result_kind, slot_index, expirations, last, input ready);
  modport sink   (input valid, result_kind, slot_index, expirations, last, output ready);
endinterface

// ----- design/ptb_ram.sv -----
`timescale 1ns / 1ps
// Slot state memory: one write port, one read port, registered read data.
// Depends on ptb_pkg for the depth and the entry type.
module ptb_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  ptb_pkg::slot_t    waddr_i,
  input  ptb_pkg::slot_ent_t wdata_i,
  input  logic              re_i,
  input  ptb_pkg::slot_t    raddr_i,
  output ptb_pkg::slot_ent_t rdata_o
);

  ptb_pkg::slot_ent_t mem [ptb_pkg::NUM_SLOTS];
  ptb_pkg::slot_ent_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ptb_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 16-bit dividend, 17-bit divisor.
// Depends on ptb_pkg for the request and response structs.
module ptb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptb_pkg::div_req_t req_i,
  output ptb_pkg::div_rsp_t rsp_o
);

  logic [4:0]  cnt_q;
  logic        done_q;
  logic [16:0] rem_q;
  logic [15:0] quo_q;
  logic [16:0] div_q;

  logic [17:0] trial;
  logic [17:0] diff;
  logic        ge;

  // One trial subtraction per step.
  assign trial = {rem_q, quo_q[15]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  // Step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= 5'd16;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 5'd1);
      if (cnt_q != 5'd0) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= 17'd0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (cnt_q != 5'd0) begin
      rem_q <= ge ? diff[16:0] : trial[16:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- design/periodic_timer_bank.sv -----
`timescale 1ns / 1ps
// Periodic timer bank top level: slot control, state memory and divider.
// Depends on ptb_pkg, ptb_if, ptb_ram and ptb_div.
//
//   channel | dir | handshake        | payload
//   in_i    | in  | valid/ready      | mode, slot, period, elapsed_ticks
//   out_o   | out | valid/ready      | result_kind, slot_index, expirations, last
//
// Register and unregister items go from idle to finish, plus any wait on the output register.
// An advance item walks all slots: a free slot is only scanned, an active slot that
// does not expire is read, loaded and written back, and an expiring slot takes a
// memory read, divider start and 16 divider steps, then a write back.
// The divider and the slot memory set the pace of the walk.
// Reset clears the active bits and the control state; there is no clearing pass.
// A stalled output holds the walk only when a second expiry event is ready.
module periodic_timer_bank (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptb_in_if.sink    in_i,
  ptb_out_if.source out_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_WR   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [ptb_pkg::NUM_SLOTS-1:0] active_q;
  ptb_pkg::slot_t idx_q;
  logic [15:0]    elapsed_q;
  logic [15:0]    n_q;
  logic [15:0]    newcd_q;

  // Held result, waiting for its successor to decide the last flag.
  logic        hv_q;
  logic [1:0]  hk_q;
  logic [2:0]  hs_q;
  logic [15:0] hn_q;

  // Output register.
  logic        ov_q;
  logic [1:0]  ok_q;
  logic [2:0]  os_q;
  logic [15:0] on_q;
  logic        ol_q;

  logic accept, out_free, adv_ok, idx_end, out_load, out_last;
  logic free_any;
  ptb_pkg::slot_t free_idx;

  logic [16:0] cd17, p17, e17;
  logic        no_exp;

  logic               ram_we, ram_re;
  ptb_pkg::slot_t     ram_waddr;
  ptb_pkg::slot_ent_t ram_wdata, ram_rdata;

  ptb_pkg::div_req_t div_req;
  ptb_pkg::div_rsp_t div_rsp;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free   = !ov_q || out_o.ready;
  assign adv_ok     = (n_q == 16'd0) || !hv_q || out_free;
  assign idx_end    = (idx_q == ptb_pkg::slot_t'(ptb_pkg::NUM_SLOTS - 1));

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ptb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = ptb_pkg::slot_t'(i);
        free_any = 1'b1;
      end
    end
  end

  // A stored zero stands for a full 65536-tick count.
  assign cd17   = (ram_rdata.countdown == 16'd0) ? 17'h10000 : {1'b0, ram_rdata.countdown};
  assign p17    = (ram_rdata.period == 16'd0) ? 17'h10000 : {1'b0, ram_rdata.period};
  assign e17    = {1'b0, elapsed_q};
  assign no_exp = (e17 < cd17);

  // Divider request: ticks past the first expiry over the period.
  assign div_req.start    = (state_q == ST_LOAD) && !no_exp;
  assign div_req.dividend = 16'(e17 - cd17);
  assign div_req.divisor  = p17;

  // Memory port control.
  assign ram_re = (state_q == ST_SCAN) && active_q[idx_q];
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '{period: ram_rdata.period, countdown: newcd_q};
    if (accept && (in_i.mode == ptb_pkg::MODE_REG) && free_any) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = '{period: in_i.period, countdown: in_i.period};
    end else if ((state_q == ST_WR) && adv_ok) begin
      ram_we = 1'b1;
    end
  end

  // Output register loads: a held event is passed on when a later one appears
  // (not last) or when the item finishes (last).
  assign out_load = ((state_q == ST_WR) && adv_ok && (n_q != 16'd0) && hv_q) ||
                    ((state_q == ST_FIN) && hv_q && out_free);
  assign out_last = (state_q == ST_FIN);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.mode == ptb_pkg::MODE_ADV) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (active_q[idx_q]) begin
          state_d = ST_LOAD;
        end else if (idx_end) begin
          state_d = ST_FIN;
        end
      end
      ST_LOAD: begin
        state_d = no_exp ? ST_WR : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        if (adv_ok) begin
          state_d = idx_end ? ST_FIN : ST_SCAN;
        end
      end
      ST_FIN: begin
        if (!hv_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      hv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && (in_i.mode == ptb_pkg::MODE_REG)) begin
        hv_q <= 1'b1;
        if (free_any) begin
          active_q[free_idx] <= 1'b1;
        end
      end else if (accept && (in_i.mode == ptb_pkg::MODE_UNREG)) begin
        hv_q <= 1'b1;
        if (32'(in_i.slot) < ptb_pkg::NUM_SLOTS) begin
          active_q[ptb_pkg::slot_t'(in_i.slot)] <= 1'b0;
        end
      end else if ((state_q == ST_WR) && adv_ok && (n_q != 16'd0)) begin
        hv_q <= 1'b1;
      end else if ((state_q == ST_FIN) && out_free) begin
        hv_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Slot walk, arithmetic results and held result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= in_i.elapsed_ticks;
      idx_q     <= '0;
      if (in_i.mode == ptb_pkg::MODE_REG) begin
        hk_q <= free_any ? ptb_pkg::KIND_REG : ptb_pkg::KIND_FULL;
        hs_q <= free_any ? 3'(free_idx) : 3'd0;
        hn_q <= 16'd0;
      end else begin
        hk_q <= ptb_pkg::KIND_UNREG;
        hs_q <= in_i.slot;
        hn_q <= 16'd0;
      end
    end
    if ((state_q == ST_SCAN) && !active_q[idx_q] && !idx_end) begin
      idx_q <= idx_q + 1'b1;
    end
    if ((state_q == ST_LOAD) && no_exp) begin
      n_q     <= 16'd0;
      newcd_q <= 16'(cd17 - e17);
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      n_q     <= div_rsp.quotient + 16'd1;
      newcd_q <= 16'(p17 - div_rsp.remainder);
    end
    if ((state_q == ST_WR) && adv_ok) begin
      if (n_q != 16'd0) begin
        hk_q <= ptb_pkg::KIND_EXPIRY;
        hs_q <= 3'(idx_q);
        hn_q <= n_q;
      end
      if (!idx_end) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ok_q <= hk_q;
      os_q <= hs_q;
      on_q <= hn_q;
      ol_q <= out_last;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.result_kind = ok_q;
  assign out_o.slot_index  = os_q;
  assign out_o.expirations = on_q;
  assign out_o.last        = ol_q;

  ptb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  ptb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

// ----- design/ptb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the periodic timer bank, attached by a bind statement.
// Depends on ptb_pkg for the result kind codes.
module ptb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_i,
  input logic [15:0] expirations_i,
  input logic        last_i
);

  // A result waiting to be taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped before it was taken");

  // Items are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again right after an item was accepted");

  // Only expiry events come in groups.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> result_kind_i == ptb_pkg::KIND_EXPIRY)
    else $error("non-final result that is not an expiry event");

  // Expiry events count at least one expiration; other results count none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == ptb_pkg::KIND_EXPIRY) |-> expirations_i != 16'd0)
    else $error("expiry event with zero expirations");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i != ptb_pkg::KIND_EXPIRY) |-> expirations_i == 16'd0)
    else $error("non-expiry result with nonzero expirations");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_kind_i (out_o.result_kind),
  .expirations_i (out_o.expirations),
  .last_i        (out_o.last)
);
